>>> design/congestion_window_controller_macros.svh
// Assertion helpers for the congestion window controller.
`ifndef CONGESTION_WINDOW_CONTROLLER_MACROS_SVH
`define CONGESTION_WINDOW_CONTROLLER_MACROS_SVH

`ifndef SYNTHESIS
`define CWC_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("congestion window controller check failed");
`define CWC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("congestion window controller sequencing check failed");
`else
`define CWC_ASSERT(label, clk, rst_n, prop)
`define CWC_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

>>> design/cwc_pkg.sv
`timescale 1ns / 1ps

package cwc_pkg;

    localparam logic [1:0] CMD_ACK  = 2'd0;
    localparam logic [1:0] CMD_TICK = 2'd1;
    localparam logic [1:0] CMD_SENT = 2'd2;

    localparam logic [2:0] REG_SEG_SIZE      = 3'd0;
    localparam logic [2:0] REG_INIT_WINDOW   = 3'd1;
    localparam logic [2:0] REG_INIT_THRESH   = 3'd2;
    localparam logic [2:0] REG_SEQ_MODULUS   = 3'd3;
    localparam logic [2:0] REG_INIT_RTO      = 3'd4;
    localparam logic [2:0] REG_START_ACK_SEQ = 3'd5;

    localparam logic [12:0] RST_SEG_SIZE    = 13'd1024;
    localparam logic [15:0] RST_INIT_WINDOW = 16'd1024;
    localparam logic [15:0] RST_INIT_THRESH = 16'd15360;
    localparam logic [16:0] RST_SEQ_MODULUS = 17'd30720;
    localparam logic [15:0] RST_INIT_RTO    = 16'd500;
    localparam logic [15:0] RST_START_ACK   = 16'd0;

    localparam logic [23:0] MAX24 = 24'hFFFFFF;
    localparam logic [15:0] MAX16 = 16'hFFFF;

    localparam int DIV_NW = 26;
    localparam int DIV_DW = 24;

    typedef enum logic [1:0] {
        MODE_SS = 2'd0,
        MODE_CA = 2'd1,
        MODE_FR = 2'd2
    } t_mode;

    typedef enum logic [2:0] {
        S_LOAD,
        S_IDLE,
        S_DISP,
        S_RTT_A,
        S_RTT_B,
        S_LOOP,
        S_DIVW,
        S_DONE
    } t_state;

    typedef enum logic [2:0] {
        TAG_LOAD,
        TAG_HALVE,
        TAG_PKTS,
        TAG_N,
        TAG_CA
    } t_div_tag;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [15:0] ack_seq;
        logic [15:0] rtt_sample;
        logic        rtt_valid;
    } t_in_item;

    typedef struct packed {
        logic [23:0] window_bytes;
        logic [23:0] threshold_bytes;
        logic [15:0] window_packets;
        logic [1:0]  mode;
        logic        may_send;
        logic        retransmit;
        logic [15:0] retransmit_seq;
        logic [23:0] rto_now;
        logic [15:0] acked_bytes;
    } t_out_item;

    typedef struct packed {
        logic [12:0] seg_size;
        logic [15:0] initial_window;
        logic [15:0] initial_threshold;
        logic [16:0] seq_modulus;
        logic [15:0] initial_rto;
        logic [15:0] start_ack_seq;
    } t_cfg;

    typedef struct packed {
        logic              go;
        logic [DIV_NW-1:0] dividend;
        logic [DIV_DW-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic              done;
        logic [DIV_NW-1:0] quot;
    } t_div_rsp;

endpackage

>>> design/cwc_div.sv
`timescale 1ns / 1ps

module cwc_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  cwc_pkg::t_div_req i_req,
    output cwc_pkg::t_div_rsp o_rsp
);

    localparam int NW = cwc_pkg::DIV_NW;
    localparam int DW = cwc_pkg::DIV_DW;
    localparam int CW = $clog2(NW);

    logic          r_busy;
    logic          r_done;
    logic [CW-1:0] r_cnt;
    logic [NW-1:0] r_quo;
    logic [DW-1:0] r_rem;
    logic [DW-1:0] r_dvs;

    logic [DW:0]   shifted;
    logic [DW:0]   trial;
    logic          ge;
    logic [DW-1:0] step_rem;

    assign shifted  = {r_rem, r_quo[NW-1]};
    assign ge       = shifted >= {1'b0, r_dvs};
    assign trial    = shifted - {1'b0, r_dvs};
    assign step_rem = ge ? trial[DW-1:0] : shifted[DW-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.go) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_cnt == CW'(NW - 1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.go) begin
            r_cnt <= '0;
            r_quo <= i_req.dividend;
            r_rem <= '0;
            r_dvs <= i_req.divisor;
        end else if (r_busy) begin
            r_cnt <= r_cnt + 1'b1;
            r_quo <= {r_quo[NW-2:0], ge};
            r_rem <= step_rem;
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_quo;

endmodule

>>> design/cwc_core.sv
`timescale 1ns / 1ps

module cwc_core #(
    parameter int RTT_FRAC_BITS = 3
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  cwc_pkg::t_cfg      i_cfg,
    input  logic               i_load,
    input  logic               i_in_valid,
    input  cwc_pkg::t_in_item  i_in_data,
    output logic               o_in_ready,
    output logic               o_idle,
    output logic               o_res_valid,
    input  logic               i_res_ready,
    output cwc_pkg::t_out_item o_res,
    output cwc_pkg::t_div_req  o_div_req,
    input  cwc_pkg::t_div_rsp  i_div_rsp
);

    localparam int NW = cwc_pkg::DIV_NW;
    localparam int DW = cwc_pkg::DIV_DW;

    cwc_pkg::t_state   r_state, n_state;
    cwc_pkg::t_div_tag r_tag, n_tag;
    cwc_pkg::t_mode    r_mode, n_mode;

    logic [1:0]    r_cmd, n_cmd;
    logic [15:0]   r_ack, n_ack;
    logic [15:0]   r_rtt, n_rtt;
    logic          r_rtt_ok, n_rtt_ok;
    logic [23:0]   r_win, n_win;
    logic [23:0]   r_thr, n_thr;
    logic [15:0]   r_pkts, n_pkts;
    logic [15:0]   r_tpk, n_tpk;
    logic [15:0]   r_unack, n_unack;
    logic [15:0]   r_last, n_last;
    logic [1:0]    r_dup, n_dup;
    logic [23:0]   r_avg, n_avg;
    logic [23:0]   r_dev, n_dev;
    logic [23:0]   r_rto, n_rto;
    logic          r_have, n_have;
    logic [23:0]   r_elap, n_elap;
    logic          r_rexmit, n_rexmit;
    logic [15:0]   r_acked, n_acked;
    logic [15:0]   r_cnt, n_cnt;
    logic          r_ca_seen, n_ca_seen;
    logic [NW-1:0] r_seg2, n_seg2;
    logic          r_div_go, n_div_go;
    logic [NW-1:0] r_div_a, n_div_a;
    logic [DW-1:0] r_div_b, n_div_b;

    logic [12:0] seg;
    logic [23:0] seg24;
    logic        in_fire;
    logic        is_new;
    logic        dup_hit;
    logic [23:0] elap_inc;
    logic        timeout;
    logic [23:0] half_thr;
    logic [15:0] seq_diff;
    logic [16:0] wrap_sum;
    logic [15:0] q16;
    logic [15:0] q_sat16;
    logic [14:0] seg3;
    logic [24:0] dup_win_sum;
    logic [23:0] dup_win;
    logic [26:0] ca_sum;
    logic [24:0] ss_sum;
    logic [23:0] ss_win;
    logic [23:0] s_fix;
    logic [23:0] d_abs;
    logic [27:0] avg_sum;
    logic [26:0] dev_sum;
    logic [26:0] rto_sum;
    logic [26:0] rto_sh;
    logic [23:0] div_ca;

    assign seg      = (i_cfg.seg_size == '0) ? 13'd1 : i_cfg.seg_size;
    assign seg24    = 24'(seg);
    assign in_fire  = i_in_valid && o_in_ready;
    assign is_new   = (r_cmd == cwc_pkg::CMD_ACK) && (r_ack != r_last);
    assign dup_hit  = (r_mode != cwc_pkg::MODE_FR) && (r_dup == 2'd2);
    assign elap_inc = (r_elap == cwc_pkg::MAX24) ? r_elap : r_elap + 24'd1;
    assign timeout  = elap_inc >= r_rto;
    assign half_thr = ((r_win >> 1) < seg24) ? seg24 : (r_win >> 1);
    assign wrap_sum = i_cfg.seq_modulus - 17'(r_last) + 17'(r_ack);
    assign seq_diff = (r_ack > r_last) ? (r_ack - r_last) : wrap_sum[15:0];
    assign q16      = i_div_rsp.quot[15:0];
    assign q_sat16  = (|i_div_rsp.quot[NW-1:16]) ? cwc_pkg::MAX16 : q16;
    assign seg3     = {1'b0, seg, 1'b0} + 15'(seg);
    assign dup_win_sum = 25'(r_thr) + 25'(seg3);
    assign dup_win  = dup_win_sum[24] ? cwc_pkg::MAX24 : dup_win_sum[23:0];
    assign ca_sum   = 27'(r_win) + 27'(i_div_rsp.quot);
    assign ss_sum   = 25'(r_win) + 25'(seg24);
    assign ss_win   = ss_sum[24] ? cwc_pkg::MAX24 : ss_sum[23:0];
    assign s_fix    = 24'(r_rtt) << RTT_FRAC_BITS;
    assign d_abs    = (s_fix >= r_avg) ? (s_fix - r_avg) : (r_avg - s_fix);
    assign avg_sum  = (28'(r_avg) << 3) - 28'(r_avg) + 28'(s_fix);
    assign dev_sum  = (27'(r_dev) << 1) + 27'(r_dev) + 27'(d_abs);
    assign rto_sum  = 27'(r_avg) + (27'(r_dev) << 2) + 27'((1 << RTT_FRAC_BITS) - 1);
    assign rto_sh   = rto_sum >> RTT_FRAC_BITS;
    assign div_ca   = (r_win == '0) ? 24'd1 : r_win;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            cwc_pkg::S_LOAD: n_state = cwc_pkg::S_DIVW;
            cwc_pkg::S_IDLE: begin
                priority if (i_load) begin
                    n_state = cwc_pkg::S_LOAD;
                end else if (i_in_valid) begin
                    n_state = cwc_pkg::S_DISP;
                end else begin
                    n_state = r_state;
                end
            end
            cwc_pkg::S_DISP: begin
                priority if (is_new) begin
                    n_state = r_rtt_ok ? cwc_pkg::S_RTT_A : cwc_pkg::S_DIVW;
                end else if (r_cmd == cwc_pkg::CMD_ACK && dup_hit) begin
                    n_state = cwc_pkg::S_DIVW;
                end else if (r_cmd == cwc_pkg::CMD_TICK && timeout) begin
                    n_state = cwc_pkg::S_DIVW;
                end else begin
                    n_state = cwc_pkg::S_DONE;
                end
            end
            cwc_pkg::S_RTT_A: n_state = cwc_pkg::S_RTT_B;
            cwc_pkg::S_RTT_B: n_state = cwc_pkg::S_DIVW;
            cwc_pkg::S_LOOP: begin
                priority if (r_cnt == '0) begin
                    n_state = r_ca_seen ? cwc_pkg::S_DIVW : cwc_pkg::S_DONE;
                end else if (r_mode == cwc_pkg::MODE_CA) begin
                    n_state = cwc_pkg::S_DIVW;
                end else begin
                    n_state = r_state;
                end
            end
            cwc_pkg::S_DIVW: begin
                if (i_div_rsp.done) begin
                    unique case (r_tag)
                        cwc_pkg::TAG_LOAD:  n_state = cwc_pkg::S_IDLE;
                        cwc_pkg::TAG_HALVE: n_state = (r_cmd == cwc_pkg::CMD_TICK) ?
                                                      cwc_pkg::S_DONE : cwc_pkg::S_DIVW;
                        cwc_pkg::TAG_PKTS:  n_state = cwc_pkg::S_DONE;
                        cwc_pkg::TAG_N:     n_state = cwc_pkg::S_LOOP;
                        cwc_pkg::TAG_CA:    n_state = cwc_pkg::S_LOOP;
                        default:            n_state = cwc_pkg::S_IDLE;
                    endcase
                end
            end
            cwc_pkg::S_DONE: begin
                if (i_res_ready) begin
                    n_state = cwc_pkg::S_IDLE;
                end
            end
            default: n_state = cwc_pkg::S_LOAD;
        endcase
    end

    always_comb begin
        n_tag     = r_tag;
        n_mode    = r_mode;
        n_cmd     = r_cmd;
        n_ack     = r_ack;
        n_rtt     = r_rtt;
        n_rtt_ok  = r_rtt_ok;
        n_win     = r_win;
        n_thr     = r_thr;
        n_pkts    = r_pkts;
        n_tpk     = r_tpk;
        n_unack   = r_unack;
        n_last    = r_last;
        n_dup     = r_dup;
        n_avg     = r_avg;
        n_dev     = r_dev;
        n_rto     = r_rto;
        n_have    = r_have;
        n_elap    = r_elap;
        n_rexmit  = r_rexmit;
        n_acked   = r_acked;
        n_cnt     = r_cnt;
        n_ca_seen = r_ca_seen;
        n_seg2    = r_seg2;
        n_div_go  = 1'b0;
        n_div_a   = r_div_a;
        n_div_b   = r_div_b;
        unique case (r_state)
            cwc_pkg::S_LOAD: begin
                n_mode   = cwc_pkg::MODE_SS;
                n_win    = 24'(i_cfg.initial_window);
                n_thr    = 24'(i_cfg.initial_threshold);
                n_pkts   = 16'd1;
                n_unack  = '0;
                n_last   = i_cfg.start_ack_seq;
                n_dup    = '0;
                n_avg    = '0;
                n_dev    = '0;
                n_rto    = (i_cfg.initial_rto == '0) ? 24'd1 : 24'(i_cfg.initial_rto);
                n_have   = 1'b0;
                n_elap   = '0;
                n_div_go = 1'b1;
                n_div_a  = NW'(i_cfg.initial_threshold);
                n_div_b  = seg24;
                n_tag    = cwc_pkg::TAG_LOAD;
            end
            cwc_pkg::S_IDLE: begin
                if (in_fire) begin
                    n_cmd     = i_in_data.cmd;
                    n_ack     = i_in_data.ack_seq;
                    n_rtt     = i_in_data.rtt_sample;
                    n_rtt_ok  = i_in_data.rtt_valid;
                    n_rexmit  = 1'b0;
                    n_acked   = '0;
                    n_ca_seen = 1'b0;
                end
            end
            cwc_pkg::S_DISP: begin
                n_seg2 = NW'(seg) * NW'(seg);
                unique case (r_cmd)
                    cwc_pkg::CMD_ACK: begin
                        priority if (is_new) begin
                            n_acked  = seq_diff;
                            n_last   = r_ack;
                            n_elap   = '0;
                            n_dup    = '0;
                            n_div_go = !r_rtt_ok;
                            n_div_a  = NW'(seq_diff);
                            n_div_b  = seg24;
                            n_tag    = cwc_pkg::TAG_N;
                        end else if (dup_hit) begin
                            n_dup    = '0;
                            n_mode   = cwc_pkg::MODE_FR;
                            n_rexmit = 1'b1;
                            n_elap   = '0;
                            n_thr    = half_thr;
                            n_div_go = 1'b1;
                            n_div_a  = NW'(half_thr);
                            n_div_b  = seg24;
                            n_tag    = cwc_pkg::TAG_HALVE;
                        end else if (r_mode != cwc_pkg::MODE_FR) begin
                            n_dup = r_dup + 2'd1;
                        end else begin
                            n_win  = ss_win;
                            n_pkts = (r_pkts == cwc_pkg::MAX16) ? r_pkts : r_pkts + 16'd1;
                        end
                    end
                    cwc_pkg::CMD_TICK: begin
                        if (timeout) begin
                            n_mode   = cwc_pkg::MODE_SS;
                            n_dup    = '0;
                            n_thr    = half_thr;
                            n_win    = seg24;
                            n_pkts   = 16'd1;
                            n_rexmit = 1'b1;
                            n_elap   = '0;
                            n_rto    = r_rto[23] ? cwc_pkg::MAX24 : {r_rto[22:0], 1'b0};
                            n_div_go = 1'b1;
                            n_div_a  = NW'(half_thr);
                            n_div_b  = seg24;
                            n_tag    = cwc_pkg::TAG_HALVE;
                        end else begin
                            n_elap = elap_inc;
                        end
                    end
                    cwc_pkg::CMD_SENT: begin
                        n_unack = (r_unack == cwc_pkg::MAX16) ? r_unack : r_unack + 16'd1;
                    end
                    default: begin
                    end
                endcase
            end
            cwc_pkg::S_RTT_A: begin
                n_have = 1'b1;
                if (!r_have) begin
                    n_avg = s_fix;
                    n_dev = s_fix >> 1;
                end else begin
                    n_avg = (|avg_sum[27:27]) ? cwc_pkg::MAX24 : avg_sum[26:3];
                    n_dev = (|dev_sum[26:26]) ? cwc_pkg::MAX24 : dev_sum[25:2];
                end
            end
            cwc_pkg::S_RTT_B: begin
                n_rto    = (rto_sh == '0) ? 24'd1 :
                           ((|rto_sh[26:24]) ? cwc_pkg::MAX24 : rto_sh[23:0]);
                n_div_go = 1'b1;
            end
            cwc_pkg::S_LOOP: begin
                priority if (r_cnt == '0) begin
                    n_div_go = r_ca_seen;
                    n_div_a  = NW'(r_win);
                    n_div_b  = seg24;
                    n_tag    = cwc_pkg::TAG_PKTS;
                end else begin
                    unique case (r_mode)
                        cwc_pkg::MODE_SS: begin
                            n_win  = ss_win;
                            n_pkts = (r_pkts == cwc_pkg::MAX16) ? r_pkts : r_pkts + 16'd1;
                            if (ss_win >= r_thr) begin
                                n_mode = cwc_pkg::MODE_CA;
                            end
                            n_cnt = r_cnt - 16'd1;
                        end
                        cwc_pkg::MODE_CA: begin
                            n_div_go = 1'b1;
                            n_div_a  = r_seg2;
                            n_div_b  = div_ca;
                            n_tag    = cwc_pkg::TAG_CA;
                        end
                        default: begin
                            n_win  = r_thr;
                            n_pkts = r_tpk;
                            n_mode = cwc_pkg::MODE_CA;
                            n_cnt  = r_cnt - 16'd1;
                        end
                    endcase
                end
            end
            cwc_pkg::S_DIVW: begin
                if (i_div_rsp.done) begin
                    unique case (r_tag)
                        cwc_pkg::TAG_LOAD: n_tpk = q16;
                        cwc_pkg::TAG_HALVE: begin
                            n_tpk = q_sat16;
                            if (r_cmd != cwc_pkg::CMD_TICK) begin
                                n_win    = dup_win;
                                n_div_go = 1'b1;
                                n_div_a  = NW'(dup_win);
                                n_div_b  = seg24;
                                n_tag    = cwc_pkg::TAG_PKTS;
                            end
                        end
                        cwc_pkg::TAG_PKTS: n_pkts = q_sat16;
                        cwc_pkg::TAG_N: begin
                            n_cnt   = q16;
                            n_unack = (r_unack > q16) ? r_unack - q16 : '0;
                        end
                        cwc_pkg::TAG_CA: begin
                            n_win     = (|ca_sum[26:24]) ? cwc_pkg::MAX24 : ca_sum[23:0];
                            n_ca_seen = 1'b1;
                            n_cnt     = r_cnt - 16'd1;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= cwc_pkg::S_LOAD;
            r_div_go <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_div_go <= n_div_go;
        end
    end

    always_ff @(posedge i_clk) begin
        r_tag     <= n_tag;
        r_mode    <= n_mode;
        r_cmd     <= n_cmd;
        r_ack     <= n_ack;
        r_rtt     <= n_rtt;
        r_rtt_ok  <= n_rtt_ok;
        r_win     <= n_win;
        r_thr     <= n_thr;
        r_pkts    <= n_pkts;
        r_tpk     <= n_tpk;
        r_unack   <= n_unack;
        r_last    <= n_last;
        r_dup     <= n_dup;
        r_avg     <= n_avg;
        r_dev     <= n_dev;
        r_rto     <= n_rto;
        r_have    <= n_have;
        r_elap    <= n_elap;
        r_rexmit  <= n_rexmit;
        r_acked   <= n_acked;
        r_cnt     <= n_cnt;
        r_ca_seen <= n_ca_seen;
        r_seg2    <= n_seg2;
        r_div_a   <= n_div_a;
        r_div_b   <= n_div_b;
    end

    assign o_idle      = (r_state == cwc_pkg::S_IDLE);
    assign o_in_ready  = o_idle && !i_load;
    assign o_res_valid = (r_state == cwc_pkg::S_DONE);

    assign o_res.window_bytes    = r_win;
    assign o_res.threshold_bytes = r_thr;
    assign o_res.window_packets  = r_pkts;
    assign o_res.mode            = r_mode;
    assign o_res.may_send        = r_unack < r_pkts;
    assign o_res.retransmit      = r_rexmit;
    assign o_res.retransmit_seq  = r_last;
    assign o_res.rto_now         = r_rto;
    assign o_res.acked_bytes     = r_acked;

    assign o_div_req.go       = r_div_go;
    assign o_div_req.dividend = r_div_a;
    assign o_div_req.divisor  = r_div_b;

endmodule

>>> design/congestion_window_controller.sv
`timescale 1ns / 1ps

// Reno-style sender congestion window controller. Each transaction on the input
// channel (ACK, timer tick or segment-sent) produces exactly one result transaction
// carrying the window, threshold, mode, RTO and retransmit request. All divisions
// go through one shared radix-2 divider, so the cost of an item is set by how
// many divides it needs: a tick, a segment-sent or an ordinary duplicate ACK needs
// none; a timeout one; the third duplicate ACK two; a new ACK acknowledging n full
// segments one in slow start plus a step per segment, or one plus one per segment
// plus one for the final packet count in avoidance (an RTT sample first passes the
// S_RTT_A and S_RTT_B states). The input is not ready while an item is in work.
// After reset and every write to registers 0 to 5 the connection state reloads.

module congestion_window_controller #(
    parameter int RTT_FRAC_BITS = 3
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  cwc_pkg::t_in_item  i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output cwc_pkg::t_out_item o_out_data,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [2:0]         i_cfg_index,
    input  logic [16:0]        i_cfg_data
);

`include "congestion_window_controller_macros.svh"

    cwc_pkg::t_cfg      r_cfg;
    logic               r_load;
    logic               r_out_valid;
    cwc_pkg::t_out_item r_out_data;

    logic               core_idle;
    logic               core_in_ready;
    logic               res_valid;
    logic               res_ready;
    logic               cfg_fire;
    logic               cfg_known;
    cwc_pkg::t_out_item res;
    cwc_pkg::t_div_req  div_req;
    cwc_pkg::t_div_rsp  div_rsp;

    assign o_cfg_ready = core_idle;
    assign cfg_fire    = i_cfg_valid && o_cfg_ready;
    assign cfg_known   = (i_cfg_index <= cwc_pkg::REG_START_ACK_SEQ);
    assign o_in_ready  = core_in_ready && !i_cfg_valid;
    assign res_ready   = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.seg_size          <= cwc_pkg::RST_SEG_SIZE;
            r_cfg.initial_window    <= cwc_pkg::RST_INIT_WINDOW;
            r_cfg.initial_threshold <= cwc_pkg::RST_INIT_THRESH;
            r_cfg.seq_modulus       <= cwc_pkg::RST_SEQ_MODULUS;
            r_cfg.initial_rto       <= cwc_pkg::RST_INIT_RTO;
            r_cfg.start_ack_seq     <= cwc_pkg::RST_START_ACK;
            r_load                  <= 1'b0;
        end else begin
            r_load <= cfg_fire && cfg_known;
            if (cfg_fire) begin
                unique case (i_cfg_index)
                    cwc_pkg::REG_SEG_SIZE:      r_cfg.seg_size          <= i_cfg_data[12:0];
                    cwc_pkg::REG_INIT_WINDOW:   r_cfg.initial_window    <= i_cfg_data[15:0];
                    cwc_pkg::REG_INIT_THRESH:   r_cfg.initial_threshold <= i_cfg_data[15:0];
                    cwc_pkg::REG_SEQ_MODULUS:   r_cfg.seq_modulus       <= i_cfg_data;
                    cwc_pkg::REG_INIT_RTO:      r_cfg.initial_rto       <= i_cfg_data[15:0];
                    cwc_pkg::REG_START_ACK_SEQ: r_cfg.start_ack_seq     <= i_cfg_data[15:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_ready) begin
            r_out_valid <= res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_ready && res_valid) begin
            r_out_data <= res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    cwc_core #(
        .RTT_FRAC_BITS (RTT_FRAC_BITS)
    ) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_load      (r_load),
        .i_in_valid  (i_in_valid && !i_cfg_valid),
        .i_in_data   (i_in_data),
        .o_in_ready  (core_in_ready),
        .o_idle      (core_idle),
        .o_res_valid (res_valid),
        .i_res_ready (res_ready),
        .o_res       (res),
        .o_div_req   (div_req),
        .i_div_rsp   (div_rsp)
    );

    cwc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    `CWC_ASSERT(a_rto_nonzero, i_clk, i_rst_n, o_out_valid |-> (o_out_data.rto_now != '0))
    `CWC_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, i_in_valid && o_in_ready, !o_in_ready)
    `CWC_ASSERT_NEXT(a_reload_after_write, i_clk, i_rst_n, cfg_fire && cfg_known, !o_in_ready)

endmodule

>>> dv/congestion_window_controller_tb.sv
`timescale 1ns / 1ps

module congestion_window_controller_tb;
    import cwc_pkg::*;

    localparam logic [1:0] CMD_NONE = 2'd3;
    localparam logic [2:0] REG_VOID_A = 3'd6;
    localparam logic [2:0] REG_VOID_B = 3'd7;
    localparam int MAX_SEGS = 40;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    t_in_item    i_in_data = '0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    t_out_item   o_out_data;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [2:0]  i_cfg_index = '0;
    logic [16:0] i_cfg_data = '0;

    congestion_window_controller u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_ready(o_in_ready), .i_in_data(i_in_data),
        .o_out_valid(o_out_valid), .i_out_ready(i_out_ready), .o_out_data(o_out_data),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // connection registers
    longint reg_seg = 1024, reg_win = 1024, reg_thr = 15360;
    longint reg_mod = 30720, reg_rto = 500, reg_start = 0;
    // connection state
    t_mode  cur_mode;
    longint wnd_b, thr_b, wnd_p, thr_p, in_flight, last_ack, dup_acks;
    longint srtt, rttvar, rto, rtt_seen, idle_ticks;

    t_out_item pending_results[$];
    int errors = 0;
    int idle_pct = 0;
    int stall_pct = 0;
    int hold_cycles = 0;
    longint cycles = 0;
    longint cycle_limit = 400000;

    function automatic longint sat24(longint v);
        return v > 64'hFFFFFF ? 64'hFFFFFF : v;
    endfunction

    function automatic longint sat16(longint v);
        return v > 64'hFFFF ? 64'hFFFF : v;
    endfunction

    function automatic longint seg_bytes();
        return reg_seg == 0 ? 1 : reg_seg;
    endfunction

    function automatic void open_connection();
        cur_mode = MODE_SS;
        wnd_b = reg_win;
        thr_b = reg_thr;
        wnd_p = 1;
        thr_p = reg_thr / seg_bytes();
        in_flight = 0;
        last_ack = reg_start;
        dup_acks = 0;
        srtt = 0;
        rttvar = 0;
        rto = reg_rto == 0 ? 1 : reg_rto;
        rtt_seen = 0;
        idle_ticks = 0;
    endfunction

    function automatic longint ack_span(longint ack);
        if (ack > last_ack) return (ack - last_ack) & 64'hFFFF;
        return (reg_mod - last_ack + ack) & 64'hFFFF;
    endfunction

    function automatic void cut_threshold();
        longint half;
        half = wnd_b / 2;
        thr_b = half < seg_bytes() ? seg_bytes() : half;
        thr_p = sat16(thr_b / seg_bytes());
    endfunction

    function automatic void fold_rtt(longint sample);
        longint s, d, r;
        s = sample << 3;
        if (rtt_seen == 0) begin
            srtt = s;
            rttvar = s >> 1;
            rtt_seen = 1;
        end else begin
            d = s >= srtt ? s - srtt : srtt - s;
            srtt = sat24((srtt * 7 + s) >> 3);
            rttvar = sat24((rttvar * 3 + d) >> 2);
        end
        r = (srtt + 4 * rttvar + 7) >> 3;
        if (r == 0) r = 1;
        rto = sat24(r);
    endfunction

    function automatic void grow_window();
        longint seg;
        seg = seg_bytes();
        if (cur_mode == MODE_SS) begin
            wnd_b = sat24(wnd_b + seg);
            wnd_p = sat16(wnd_p + 1);
            if (wnd_b >= thr_b) cur_mode = MODE_CA;
        end else if (cur_mode == MODE_CA) begin
            wnd_b = sat24(wnd_b + (seg * seg) / (wnd_b == 0 ? 1 : wnd_b));
            wnd_p = sat16(wnd_b / seg);
        end else begin
            wnd_b = thr_b;
            wnd_p = thr_p;
            cur_mode = MODE_CA;
        end
    endfunction

    function automatic t_out_item advance_connection(t_in_item it);
        t_out_item res;
        longint seg, span, nseg, acked, rexmit;
        seg = seg_bytes();
        acked = 0;
        rexmit = 0;
        if (it.cmd == CMD_ACK) begin
            if (it.ack_seq != last_ack) begin
                if (it.rtt_valid) fold_rtt(it.rtt_sample);
                span = ack_span(it.ack_seq);
                acked = span;
                last_ack = it.ack_seq;
                nseg = span / seg;
                in_flight = in_flight > nseg ? in_flight - nseg : 0;
                for (longint k = 0; k < nseg; k++) grow_window();
                idle_ticks = 0;
                dup_acks = 0;
            end else if (cur_mode != MODE_FR) begin
                dup_acks++;
                if (dup_acks >= 3) begin
                    dup_acks = 0;
                    cur_mode = MODE_FR;
                    cut_threshold();
                    wnd_b = sat24(thr_b + 3 * seg);
                    wnd_p = sat16(wnd_b / seg);
                    rexmit = 1;
                    idle_ticks = 0;
                end
            end else begin
                wnd_b = sat24(wnd_b + seg);
                wnd_p = sat16(wnd_p + 1);
            end
        end else if (it.cmd == CMD_TICK) begin
            idle_ticks = sat24(idle_ticks + 1);
            if (idle_ticks >= rto) begin
                cur_mode = MODE_SS;
                dup_acks = 0;
                cut_threshold();
                wnd_b = seg;
                wnd_p = 1;
                rexmit = 1;
                idle_ticks = 0;
                rto = sat24(rto * 2);
            end
        end else if (it.cmd == CMD_SENT) begin
            in_flight = sat16(in_flight + 1);
        end
        res.window_bytes = 24'(wnd_b);
        res.threshold_bytes = 24'(thr_b);
        res.window_packets = 16'(wnd_p);
        res.mode = cur_mode;
        res.may_send = in_flight < wnd_p;
        res.retransmit = 1'(rexmit);
        res.retransmit_seq = 16'(last_ack);
        res.rto_now = 24'(rto);
        res.acked_bytes = 16'(acked);
        return res;
    endfunction

    task automatic report(string field, longint got, longint want);
        $display("[%0t] mismatch %s: got %0d expected %0d", $time, field, got, want);
        errors++;
    endtask

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > cycle_limit) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    always @(negedge i_clk) begin
        if (hold_cycles > 0) begin
            i_out_ready <= 1'b0;
            hold_cycles <= hold_cycles - 1;
        end else begin
            i_out_ready <= $urandom_range(0, 99) >= stall_pct;
        end
    end

    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_results.size() == 0) begin
                report("unexpected result transaction", 1, 0);
            end else begin
                want = pending_results.pop_front();
                if (o_out_data.window_bytes !== want.window_bytes)
                    report("window_bytes", o_out_data.window_bytes, want.window_bytes);
                if (o_out_data.threshold_bytes !== want.threshold_bytes)
                    report("threshold_bytes", o_out_data.threshold_bytes,
                           want.threshold_bytes);
                if (o_out_data.window_packets !== want.window_packets)
                    report("window_packets", o_out_data.window_packets, want.window_packets);
                if (o_out_data.mode !== want.mode)
                    report("mode", o_out_data.mode, want.mode);
                if (o_out_data.may_send !== want.may_send)
                    report("may_send", o_out_data.may_send, want.may_send);
                if (o_out_data.retransmit !== want.retransmit)
                    report("retransmit", o_out_data.retransmit, want.retransmit);
                if (o_out_data.retransmit_seq !== want.retransmit_seq)
                    report("retransmit_seq", o_out_data.retransmit_seq, want.retransmit_seq);
                if (o_out_data.rto_now !== want.rto_now)
                    report("rto_now", o_out_data.rto_now, want.rto_now);
                if (o_out_data.acked_bytes !== want.acked_bytes)
                    report("acked_bytes", o_out_data.acked_bytes, want.acked_bytes);
            end
        end
    end

    // offer one transaction; typed fields override the predicted ones where given
    task automatic offer(t_in_item it, bit typed, longint t_win, t_mode t_md, bit t_rex);
        t_out_item res;
        longint nseg;
        while ($urandom_range(0, 99) < idle_pct) begin
            i_in_valid = 1'b0;
            @(negedge i_clk);
        end
        i_in_valid = 1'b1;
        i_in_data = it;
        do @(posedge i_clk); while (!o_in_ready);
        nseg = 0;
        if (it.cmd == CMD_ACK && it.ack_seq != last_ack) nseg = ack_span(it.ack_seq) / seg_bytes();
        cycle_limit += 1500 + 120 * nseg;
        res = advance_connection(it);
        if (typed) begin
            res.window_bytes = 24'(t_win);
            res.mode = t_md;
            res.retransmit = t_rex;
        end
        pending_results.push_back(res);
        @(negedge i_clk);
    endtask

    function automatic t_in_item random_item();
        t_in_item it;
        int r;
        longint seg;
        seg = seg_bytes();
        r = $urandom_range(0, 99);
        it.rtt_valid = 1'($urandom_range(0, 1));
        case ($urandom_range(0, 9))
            8: it.rtt_sample = 16'($urandom);
            9: it.rtt_sample = $urandom_range(0, 1) ? 16'hFFFF : 16'h0;
            default: it.rtt_sample = 16'($urandom_range(1, 24));
        endcase
        it.cmd = CMD_ACK;
        it.ack_seq = 16'(last_ack);
        if (r < 45) it.ack_seq = 16'(last_ack + $urandom_range(0, 4) * seg
                                     + $urandom_range(0, seg - 1));
        else if (r < 60) it.ack_seq = 16'(last_ack);
        else if (r < 75) it.cmd = CMD_SENT;
        else if (r < 95) it.cmd = CMD_TICK;
        else if (r < 98) it.ack_seq = 16'($urandom);
        else begin
            it.cmd = CMD_NONE;
            it.ack_seq = 16'($urandom);
        end
        if (it.cmd == CMD_ACK && it.ack_seq != last_ack
            && ack_span(it.ack_seq) / seg > MAX_SEGS)
            it.ack_seq = 16'(last_ack);
        return it;
    endfunction

    task automatic write_reg(logic [2:0] idx, longint val);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data = 17'(val);
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
        case (idx)
            REG_SEG_SIZE:      reg_seg = val & 16'h1FFF;
            REG_INIT_WINDOW:   reg_win = val & 16'hFFFF;
            REG_INIT_THRESH:   reg_thr = val & 16'hFFFF;
            REG_SEQ_MODULUS:   reg_mod = val & 17'h1FFFF;
            REG_INIT_RTO:      reg_rto = val & 16'hFFFF;
            REG_START_ACK_SEQ: reg_start = val & 16'hFFFF;
            default: ;
        endcase
        if (idx <= REG_START_ACK_SEQ) open_connection();
    endtask

    typedef struct {
        logic [1:0]  cmd;
        logic [15:0] ack;
        logic [15:0] rtt;
        bit          rv;
        bit          typed;
        longint      win;
        t_mode       md;
        bit          rex;
    } t_row;

    t_row script[] = '{
        '{CMD_SENT, 16'd0,     16'd0,     0, 1, 1024, MODE_SS, 0},
        '{CMD_NONE, 16'hFFFF,  16'hFFFF,  1, 1, 1024, MODE_SS, 0},
        '{CMD_ACK,  16'd0,     16'd0,     0, 1, 1024, MODE_SS, 0},
        '{CMD_ACK,  16'd0,     16'd0,     0, 1, 1024, MODE_SS, 0},
        '{CMD_ACK,  16'd0,     16'd0,     0, 1, 4096, MODE_FR, 1},
        '{CMD_ACK,  16'd0,     16'd0,     0, 1, 5120, MODE_FR, 0},
        '{CMD_ACK,  16'd2048,  16'd100,   1, 0, 0, MODE_SS, 0},
        '{CMD_TICK, 16'd0,     16'd0,     0, 0, 0, MODE_SS, 0},
        '{CMD_SENT, 16'd0,     16'd0,     0, 0, 0, MODE_SS, 0},
        '{CMD_ACK,  16'd2500,  16'd0,     1, 0, 0, MODE_SS, 0},
        '{CMD_ACK,  16'hFFFF,  16'hFFFF,  1, 0, 0, MODE_SS, 0},
        '{CMD_ACK,  16'd0,     16'd1,     1, 0, 0, MODE_SS, 0},
        '{CMD_ACK,  16'd1024,  16'd0,     0, 0, 0, MODE_SS, 0},
        '{CMD_TICK, 16'hFFFF,  16'hFFFF,  1, 0, 0, MODE_SS, 0}
    };

    typedef struct {
        longint seg, win, thr, modulus, rto0, start;
        int     idle, stall;
    } t_phase;

    t_phase phases[] = '{
        '{1024, 1024, 15360, 30720, 500, 0, 0, 0},
        '{1, 1, 1, 2, 1, 0, 67, 0},
        '{8191, 65535, 65535, 131071, 65535, 65535, 0, 67},
        '{0, 0, 0, 65536, 0, 12345, 30, 30},
        '{536, 4000, 30000, 65536, 4, 100, 0, 0}
    };

    initial begin
        t_in_item it;
        open_connection();
        repeat (7) @(negedge i_clk);
        i_rst_n = 1'b1;
        foreach (script[k]) begin
            it.cmd = script[k].cmd;
            it.ack_seq = script[k].ack;
            it.rtt_sample = script[k].rtt;
            it.rtt_valid = script[k].rv;
            offer(it, script[k].typed, script[k].win, script[k].md, script[k].rex);
        end
        foreach (phases[p]) begin
            i_in_valid = 1'b0;
            wait (pending_results.size() == 0);
            repeat (4) @(negedge i_clk);
            idle_pct = 0;
            stall_pct = 0;
            if (p == 2) begin
                write_reg(REG_VOID_A, 17'h1FFFF);
                write_reg(REG_VOID_B, 17'd0);
            end
            write_reg(REG_SEG_SIZE, phases[p].seg);
            write_reg(REG_INIT_WINDOW, phases[p].win);
            write_reg(REG_INIT_THRESH, phases[p].thr);
            write_reg(REG_SEQ_MODULUS, phases[p].modulus);
            write_reg(REG_INIT_RTO, phases[p].rto0);
            write_reg(REG_START_ACK_SEQ, phases[p].start);
            idle_pct = phases[p].idle;
            stall_pct = phases[p].stall;
            for (int k = 0; k < 330; k++) begin
                if (p == 1 && k == 60) hold_cycles = 400;
                if (p == 2 && k == 100) begin
                    i_in_valid = 1'b0;
                    wait (pending_results.size() == 0);
                    @(negedge i_clk);
                end
                offer(random_item(), 0, 0, MODE_SS, 0);
            end
        end
        i_in_valid = 1'b0;
        wait (pending_results.size() == 0);
        repeat (200) @(negedge i_clk);
        if (errors == 0 && pending_results.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
